// ===== design/spe_pkg.sv =====
// Constants, types and elaboration-time helpers for the sinusoidal position encoder.
`default_nettype none

package spe_pkg;

	localparam int MAX_MODEL_DIM = 1024;
	localparam int DIM_W         = 11;

	// log2(10000) in Q24, pi/2 in Q30, 2*pi in Q31
	localparam logic [27:0] LOG2_1E4_Q24 = 28'd222930821;
	localparam logic [30:0] PIH_Q30      = 31'd1686629713;
	localparam logic [33:0] TWO_PI_Q31   = 34'd13493037704;

	localparam int TDIV_BITS    = 29;  // exponent quotient bits kept (ti below 32)
	localparam int FRAC_BITS    = 24;
	localparam int MOD_STEPS    = 10;
	localparam int PHASE_BITS   = 24;
	localparam int TAYLOR_TERMS = 6;

	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	typedef struct packed {
		logic [11:0]        pos;
		logic               odd;
		logic signed [23:0] embed;
	} item_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = v;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > x) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// 2^(-2^-(j+1)) in Q31
	function automatic logic [30:0] exp_root(input int j);
		logic [63:0] r;
		r = isqrt64(64'd1 << 61);
		for (int i = 0; i < j; i++) begin
			r = isqrt64(r << 31);
		end
		return r[30:0];
	endfunction

endpackage

`default_nettype wire

// ===== design/sinusoidal_position_encode_add.sv =====
// Top level: sinusoidal positional encoding added to one embedding word, fully pipelined.
`default_nettype none

// Takes one word per cycle while the pipeline is not stalled and returns one word per word taken, in order.
// The angle is position * 10000^(-e/model_dim), e the dimension index rounded down to even;
// even dimensions take the sine, odd ones the cosine, in Q1.16, and the sum with the embedding
// value saturates to Q7.16. The latency is set by the chain of one-bit-per-stage long
// divisions (exponent by model_dim, angle modulo 2*pi, phase in turns), by the 24 stages of
// the fractional power of two and by the 12 stages of the Taylor series. All stages advance
// together whenever the output register is empty or being read, so a stall holds every word
// in place. model_dim is written through the cfg channel, which is always ready; write it only
// while the pipeline is empty.
module sinusoidal_position_encode_add
	import spe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // position[11:0], dim_index[21:12], embed_value[45:22], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // encoding[17:0], sum_value[41:18], zero
	output logic        m_tuser,   // saturated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data   // model_dim
);

	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_MODEL_DIM);

	logic             adv;
	logic [DIM_W-1:0] d_q;

	// Whole pipe moves as one: advance when the output slot frees up
	assign adv       = ~m_tvalid | m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	// Hold model_dim already clamped to 1..MAX_MODEL_DIM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= DIM_W'(512);
		end else if (cfg_valid) begin
			priority if (cfg_data == '0) d_q <= DIM_W'(1);
			else if (cfg_data > DIM_MAX) d_q <= DIM_MAX;
			else d_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------- stage 1: e * log2(1e4)
	logic        vld_s1;
	item_t       it_s1;
	logic [37:0] num_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1.pos   <= s_tdata[11:0];
			it_s1.odd   <= s_tdata[12];
			it_s1.embed <= s_tdata[45:22];
			num_s1      <= 38'({s_tdata[21:13], 1'b0}) * 38'(LOG2_1E4_Q24);
		end
	end

	// ---------------------------------------------------------------- exponent divider
	// Restoring division by model_dim, one quotient bit a stage. A quotient of 2^29 or
	// more means ti >= 32, so the frequency drops to zero.
	logic                 div_vld_s [0:TDIV_BITS];
	item_t                div_it_s  [0:TDIV_BITS];
	logic [DIM_W-1:0]     div_rem_s [0:TDIV_BITS];
	logic [TDIV_BITS-1:0] div_low_s [0:TDIV_BITS];
	logic [TDIV_BITS-1:0] div_quo_s [0:TDIV_BITS];
	logic                 div_ovf_s [0:TDIV_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_vld_s[0] <= 1'b0;
		else if (adv) div_vld_s[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_it_s[0]  <= it_s1;
			div_ovf_s[0] <= 40'(num_s1) >= (40'(d_q) << TDIV_BITS);
			div_rem_s[0] <= DIM_W'(num_s1[37:TDIV_BITS]);
			div_low_s[0] <= num_s1[TDIV_BITS-1:0];
			div_quo_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < TDIV_BITS; i++) begin : g_div
		localparam int B = TDIV_BITS - 1 - i;
		logic [DIM_W:0] r;
		logic           ge;

		assign r  = {div_rem_s[i], div_low_s[i][B]};
		assign ge = r >= {1'b0, d_q};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_vld_s[i+1] <= 1'b0;
			else if (adv) div_vld_s[i+1] <= div_vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_it_s[i+1]  <= div_it_s[i];
				div_ovf_s[i+1] <= div_ovf_s[i];
				div_low_s[i+1] <= div_low_s[i];
				div_rem_s[i+1] <= ge ? DIM_W'(r - {1'b0, d_q}) : r[DIM_W-1:0];
				div_quo_s[i+1] <= {div_quo_s[i][TDIV_BITS-2:0], ge};
			end
		end
	end

	// ---------------------------------------------------------------- 2^(-tf) in Q31
	logic                 ex_vld_s [0:FRAC_BITS];
	item_t                ex_it_s  [0:FRAC_BITS];
	logic [31:0]          ex_m_s   [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] ex_tf_s  [0:FRAC_BITS];
	logic [4:0]           ex_ti_s  [0:FRAC_BITS];
	logic                 ex_ovf_s [0:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ex_vld_s[0] <= 1'b0;
		else if (adv) ex_vld_s[0] <= div_vld_s[TDIV_BITS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_it_s[0]  <= div_it_s[TDIV_BITS];
			ex_ovf_s[0] <= div_ovf_s[TDIV_BITS];
			ex_m_s[0]   <= 32'h8000_0000;
			ex_tf_s[0]  <= div_quo_s[TDIV_BITS][FRAC_BITS-1:0];
			ex_ti_s[0]  <= div_quo_s[TDIV_BITS][TDIV_BITS-1:FRAC_BITS];
		end
	end

	for (genvar j = 0; j < FRAC_BITS; j++) begin : g_exp
		localparam logic [30:0] ROOT = exp_root(j);
		logic [62:0] prod;

		assign prod = 63'(ex_m_s[j]) * 63'(ROOT);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ex_vld_s[j+1] <= 1'b0;
			else if (adv) ex_vld_s[j+1] <= ex_vld_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ex_it_s[j+1]  <= ex_it_s[j];
				ex_ovf_s[j+1] <= ex_ovf_s[j];
				ex_tf_s[j+1]  <= ex_tf_s[j];
				ex_ti_s[j+1]  <= ex_ti_s[j];
				ex_m_s[j+1]   <= ex_tf_s[j][FRAC_BITS-1-j] ? prod[62:31] : ex_m_s[j];
			end
		end
	end

	// ---------------------------------------------------------------- frequency, angle
	logic        frq_vld_s, ang_vld_s;
	item_t       frq_it_s, ang_it_s;
	logic [31:0] frq_s;
	logic [43:0] ang_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frq_vld_s <= 1'b0;
			ang_vld_s <= 1'b0;
		end else if (adv) begin
			frq_vld_s <= ex_vld_s[FRAC_BITS];
			ang_vld_s <= frq_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frq_it_s <= ex_it_s[FRAC_BITS];
			frq_s    <= ex_ovf_s[FRAC_BITS] ? '0 : (ex_m_s[FRAC_BITS] >> ex_ti_s[FRAC_BITS]);
			ang_it_s <= frq_it_s;
			ang_s    <= 44'(frq_it_s.pos) * 44'(frq_s);
		end
	end

	// ---------------------------------------------------------------- angle mod 2*pi
	logic        md_vld_s [0:MOD_STEPS-1];
	item_t       md_it_s  [0:MOD_STEPS-1];
	logic [43:0] md_a_s   [0:MOD_STEPS-1];

	for (genvar i = 0; i < MOD_STEPS; i++) begin : g_mod
		localparam int          K   = MOD_STEPS - 1 - i;
		localparam logic [43:0] SUB = 44'(TWO_PI_Q31) << K;
		logic        v_in;
		item_t       it_in;
		logic [43:0] a_in;

		if (i == 0) begin : g_src
			assign v_in  = ang_vld_s;
			assign it_in = ang_it_s;
			assign a_in  = ang_s;
		end else begin : g_src
			assign v_in  = md_vld_s[i-1];
			assign it_in = md_it_s[i-1];
			assign a_in  = md_a_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) md_vld_s[i] <= 1'b0;
			else if (adv) md_vld_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				md_it_s[i] <= it_in;
				md_a_s[i]  <= (a_in >= SUB) ? a_in - SUB : a_in;
			end
		end
	end

	// ---------------------------------------------------------------- phase in Q24 turns
	logic                  ph_vld_s [0:PHASE_BITS-1];
	item_t                 ph_it_s  [0:PHASE_BITS-1];
	logic [33:0]           ph_r_s   [0:PHASE_BITS-1];
	logic [PHASE_BITS-1:0] ph_q_s   [0:PHASE_BITS-1];

	for (genvar i = 0; i < PHASE_BITS; i++) begin : g_ph
		logic                  v_in;
		item_t                 it_in;
		logic [33:0]           r_in;
		logic [PHASE_BITS-1:0] q_in;
		logic [34:0]           r2;
		logic                  ge;

		if (i == 0) begin : g_src
			assign v_in  = md_vld_s[MOD_STEPS-1];
			assign it_in = md_it_s[MOD_STEPS-1];
			assign r_in  = md_a_s[MOD_STEPS-1][33:0];
			assign q_in  = '0;
		end else begin : g_src
			assign v_in  = ph_vld_s[i-1];
			assign it_in = ph_it_s[i-1];
			assign r_in  = ph_r_s[i-1];
			assign q_in  = ph_q_s[i-1];
		end

		assign r2 = {r_in, 1'b0};
		assign ge = r2 >= 35'(TWO_PI_Q31);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ph_vld_s[i] <= 1'b0;
			else if (adv) ph_vld_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ph_it_s[i] <= it_in;
				ph_r_s[i]  <= ge ? 34'(r2 - 35'(TWO_PI_Q31)) : r2[33:0];
				ph_q_s[i]  <= {q_in[PHASE_BITS-2:0], ge};
			end
		end
	end

	// ---------------------------------------------------------------- x in Q30 radians, x^2
	logic        x_vld_s;
	item_t       x_it_s;
	quad_t       x_quad_s;
	logic [30:0] x_s;
	logic [52:0] xq_prod;

	assign xq_prod = 53'(ph_q_s[PHASE_BITS-1][21:0]) * 53'(PIH_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) x_vld_s <= 1'b0;
		else if (adv) x_vld_s <= ph_vld_s[PHASE_BITS-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_it_s   <= ph_it_s[PHASE_BITS-1];
			x_quad_s <= quad_t'(ph_q_s[PHASE_BITS-1][23:22]);
			x_s      <= xq_prod[52:22];
		end
	end

	// Taylor series; term k is added one stage after it is formed
	logic               td_vld_s  [0:TAYLOR_TERMS];
	item_t              td_it_s   [0:TAYLOR_TERMS];
	quad_t              td_quad_s [0:TAYLOR_TERMS];
	logic [31:0]        td_x2_s   [0:TAYLOR_TERMS];
	logic [31:0]        td_ts_s   [0:TAYLOR_TERMS];
	logic [31:0]        td_tc_s   [0:TAYLOR_TERMS];
	logic signed [33:0] td_as_s   [0:TAYLOR_TERMS];
	logic signed [33:0] td_ac_s   [0:TAYLOR_TERMS];

	logic               tp_vld_s  [1:TAYLOR_TERMS];
	item_t              tp_it_s   [1:TAYLOR_TERMS];
	quad_t              tp_quad_s [1:TAYLOR_TERMS];
	logic [31:0]        tp_x2_s   [1:TAYLOR_TERMS];
	logic [31:0]        tp_ps_s   [1:TAYLOR_TERMS];
	logic [31:0]        tp_pc_s   [1:TAYLOR_TERMS];
	logic signed [33:0] tp_as_s   [1:TAYLOR_TERMS];
	logic signed [33:0] tp_ac_s   [1:TAYLOR_TERMS];

	logic [61:0] xx_prod;
	assign xx_prod = 62'(x_s) * 62'(x_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) td_vld_s[0] <= 1'b0;
		else if (adv) td_vld_s[0] <= x_vld_s;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			td_it_s[0]   <= x_it_s;
			td_quad_s[0] <= x_quad_s;
			td_x2_s[0]   <= xx_prod[61:30];
			td_ts_s[0]   <= 32'(x_s);
			td_tc_s[0]   <= 32'h4000_0000;
			td_as_s[0]   <= '0;
			td_ac_s[0]   <= '0;
		end
	end

	for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_tay
		localparam bit          ADD = ((k - 1) % 2) == 0;
		localparam int          CS  = (2 * k) * (2 * k + 1);
		localparam int          CC  = (2 * k - 1) * (2 * k);
		localparam int          LS  = $clog2(CS);
		localparam int          LC  = $clog2(CC);
		// Exact floor division of a 32-bit value by a small constant
		localparam logic [63:0] MS  = ((64'd1 << (32 + LS)) + 64'(CS) - 64'd1) / CS;
		localparam logic [63:0] MC  = ((64'd1 << (32 + LC)) + 64'(CC) - 64'd1) / CC;

		logic [63:0]        ps_prod, pc_prod;
		logic [64:0]        ds_prod, dc_prod;
		logic signed [33:0] es, ec;

		assign ps_prod = 64'(td_ts_s[k-1]) * 64'(td_x2_s[k-1]);
		assign pc_prod = 64'(td_tc_s[k-1]) * 64'(td_x2_s[k-1]);
		assign es      = $signed({2'b00, td_ts_s[k-1]});
		assign ec      = $signed({2'b00, td_tc_s[k-1]});
		assign ds_prod = 65'(tp_ps_s[k]) * 65'(MS[32:0]);
		assign dc_prod = 65'(tp_pc_s[k]) * 65'(MC[32:0]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tp_vld_s[k] <= 1'b0;
				td_vld_s[k] <= 1'b0;
			end else if (adv) begin
				tp_vld_s[k] <= td_vld_s[k-1];
				td_vld_s[k] <= tp_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				tp_it_s[k]   <= td_it_s[k-1];
				tp_quad_s[k] <= td_quad_s[k-1];
				tp_x2_s[k]   <= td_x2_s[k-1];
				tp_ps_s[k]   <= ps_prod[61:30];
				tp_pc_s[k]   <= pc_prod[61:30];
				tp_as_s[k]   <= ADD ? td_as_s[k-1] + es : td_as_s[k-1] - es;
				tp_ac_s[k]   <= ADD ? td_ac_s[k-1] + ec : td_ac_s[k-1] - ec;

				td_it_s[k]   <= tp_it_s[k];
				td_quad_s[k] <= tp_quad_s[k];
				td_x2_s[k]   <= tp_x2_s[k];
				td_ts_s[k]   <= 32'(ds_prod >> (32 + LS));
				td_tc_s[k]   <= 32'(dc_prod >> (32 + LC));
				td_as_s[k]   <= tp_as_s[k];
				td_ac_s[k]   <= tp_ac_s[k];
			end
		end
	end

	// ---------------------------------------------------------------- last term, rounding
	logic               sa_vld_s, sr_vld_s;
	item_t              sa_it_s, sr_it_s;
	quad_t              sa_quad_s;
	logic signed [33:0] sa_s_s, sa_c_s;
	logic [17:0]        sr_enc_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sa_vld_s <= 1'b0;
			sr_vld_s <= 1'b0;
		end else if (adv) begin
			sa_vld_s <= td_vld_s[TAYLOR_TERMS];
			sr_vld_s <= sa_vld_s;
		end
	end

	logic signed [33:0] v;
	logic               neg;
	logic [33:0]        mag;
	logic [19:0]        rnd;
	logic [16:0]        em;
	logic [17:0]        enc_d;

	// Fold the quadrant back, round the magnitude to Q16 half up, clip at one
	always_comb begin
		unique case (sa_quad_s)
			QUAD_I:   v = sa_it_s.odd ? sa_c_s : sa_s_s;
			QUAD_II:  v = sa_it_s.odd ? -sa_s_s : sa_c_s;
			QUAD_III: v = sa_it_s.odd ? -sa_c_s : -sa_s_s;
			QUAD_IV:  v = sa_it_s.odd ? sa_s_s : -sa_c_s;
			default:  v = sa_s_s;
		endcase
		neg   = v[33];
		mag   = neg ? 34'(-v) : 34'(v);
		rnd   = 20'((mag + 34'd8192) >> 14);
		em    = (rnd > 20'd65536) ? 17'd65536 : rnd[16:0];
		enc_d = neg ? 18'(-{1'b0, em}) : {1'b0, em};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_it_s   <= td_it_s[TAYLOR_TERMS];
			sa_quad_s <= td_quad_s[TAYLOR_TERMS];
			sa_s_s    <= td_as_s[TAYLOR_TERMS] + $signed({2'b00, td_ts_s[TAYLOR_TERMS]});
			sa_c_s    <= td_ac_s[TAYLOR_TERMS] + $signed({2'b00, td_tc_s[TAYLOR_TERMS]});
			sr_it_s   <= sa_it_s;
			sr_enc_s  <= enc_d;
		end
	end

	// ---------------------------------------------------------------- sum and output register
	logic [24:0] sum;
	logic        ovf;

	assign sum = 25'({sr_it_s.embed[23], sr_it_s.embed}) + 25'({{7{sr_enc_s[17]}}, sr_enc_s});
	assign ovf = sum[24] != sum[23];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (adv) m_tvalid <= sr_vld_s;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata[17:0]  <= sr_enc_s;
			m_tdata[41:18] <= ovf ? (sum[24] ? 24'h800000 : 24'h7FFFFF) : sum[23:0];
			m_tdata[47:42] <= '0;
			m_tuser        <= ovf;
		end
	end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the sinusoidal position encoder with saturating add.
`timescale 1ns / 100ps
`default_nettype none

// Predicts each word in fixed point, as the block defines it, and compares in arrival order.
class enc_scoreboard;
	typedef struct {
		logic signed [17:0] enc;
		logic signed [23:0] sum;
		logic               sat;
	} enc_word_t;

	enc_word_t   pending[$];
	logic [10:0] model_dim;
	logic [63:0] roots[24];
	int          mismatches;

	function new();
		model_dim  = 11'd512;
		mismatches = 0;
		roots[0]   = floor_sqrt(64'd1 << 61);
		for (int j = 1; j < 24; j++) roots[j] = floor_sqrt(roots[j-1] << 31);
	endfunction

	// bitwise floor square root, operand below 2^64
	function logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c <= v) r = c;
		end
		return r;
	endfunction

	// Taylor series in Q30: sine to x^13, cosine to x^12
	function longint series_q30(input logic [63:0] x, input bit cosine);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] n;
		longint      acc;
		x2   = (x * x) >> 30;
		term = cosine ? (64'd1 << 30) : x;
		n    = cosine ? 64'd0 : 64'd1;
		acc  = longint'(term);
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / ((n + 1) * (n + 2));
			n    = n + 2;
			if (k & 1) acc -= longint'(term);
			else acc += longint'(term);
		end
		return acc;
	endfunction

	function void note_word(input logic [11:0] pos, input logic [9:0] dim,
			input logic signed [23:0] embed);
		enc_word_t   w;
		logic [63:0] d, e, t, ti, m, freq, rem, phase, q, x;
		logic [1:0]  quad;
		longint      s, c, v, sum;
		logic [63:0] mag;
		bit          neg;
		d = model_dim;
		if (d == 0) d = 1;
		if (d > 1024) d = 1024;
		e  = dim & ~64'd1;
		t  = (e * 64'd222930821) / d;
		ti = t >> 24;
		m  = 64'd1 << 31;
		for (int j = 0; j < 24; j++) if (t[23-j]) m = (m * roots[j]) >> 31;
		freq  = (ti >= 32) ? 64'd0 : (m >> ti);
		rem   = (pos * freq) % 64'd13493037704;
		phase = (rem << 24) / 64'd13493037704;
		quad  = phase[23:22];
		q     = phase & 64'h3FFFFF;
		x     = (q * 64'd1686629713) >> 22;
		s = series_q30(x, 1'b0);
		c = series_q30(x, 1'b1);
		case (quad)
			spe_pkg::QUAD_I:   v = dim[0] ? c : s;
			spe_pkg::QUAD_II:  v = dim[0] ? -s : c;
			spe_pkg::QUAD_III: v = dim[0] ? -c : -s;
			default:           v = dim[0] ? s : -c;
		endcase
		neg = v < 0;
		mag = neg ? -v : v;
		mag = (mag + (64'd1 << 13)) >> 14;
		if (mag > 65536) mag = 65536;
		w.enc = neg ? -longint'(mag) : longint'(mag);
		sum   = longint'(embed) + longint'(w.enc);
		w.sat = 1'b0;
		if (sum > 8388607) begin
			sum = 8388607; w.sat = 1'b1;
		end else if (sum < -8388608) begin
			sum = -8388608; w.sat = 1'b1;
		end
		w.sum = sum;
		pending.push_back(w);
	endfunction

	function void check_word(input logic [47:0] data, input logic flag);
		enc_word_t w;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected word %h", data);
			return;
		end
		w = pending.pop_front();
		if (data[17:0] !== w.enc || data[41:18] !== w.sum || flag !== w.sat) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp enc %0d sum %0d sat %0b, got enc %0d sum %0d sat %0b",
					w.enc, w.sum, w.sat, $signed(data[17:0]), $signed(data[41:18]), flag);
		end
	endfunction
endclass

module testbench;
	import spe_pkg::*;

	localparam int LATENCY = 130;
	localparam int LIMIT   = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] cfg_data = '0;

	enc_scoreboard encodings = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;

	sinusoidal_position_encode_add dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// cycle limit: end the run if the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: stall at the chosen rate, check each word taken
	always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) encodings.check_word(m_tdata, m_tuser);
	end

	// drive one word, idling first at the chosen rate; valid stays high into the next word
	task automatic send_word(input logic [11:0] pos, input logic [9:0] dim,
			input logic [23:0] embed);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, embed, dim, pos};
		do @(posedge clk); while (!s_tready);
		encodings.note_word(pos, dim, embed);
	endtask

	// hold off until every word is back, then let the pipeline drain
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (encodings.pending.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_model_dim(input logic [10:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		encodings.model_dim = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random(input int count);
		logic [9:0]  dim;
		logic [23:0] embed;
		int          md;
		for (int i = 0; i < count; i++) begin
			md = (encodings.model_dim == 0) ? 1 :
				(encodings.model_dim > 1024) ? 1024 : encodings.model_dim;
			// mostly dimensions in use, some beyond model_dim
			dim = ($urandom_range(9) < 8 && md <= 1024) ? $urandom_range(md - 1) : $urandom;
			case ($urandom_range(7))
				0: embed = 24'h7FFFFF - $urandom_range(65536);
				1: embed = 24'h800000 + $urandom_range(65536);
				default: embed = $urandom;
			endcase
			send_word($urandom, dim, embed);
			if (i == count / 2 && $urandom_range(1)) drain();
		end
	endtask

	initial begin
		int modes[4][2];
		logic [10:0] dims[6];
		modes = '{'{0, 0}, '{87, 0}, '{0, 87}, '{36, 36}};
		dims  = '{11'd512, 11'd1, 11'd1024, 11'd0, 11'd2047, 11'd64};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset setting, extremes, saturation both ways
		send_word(12'd0, 10'd0, 24'd0);
		send_word(12'd0, 10'd1, 24'h7FFFFF);
		send_word(12'd4095, 10'd0, 24'h800000);
		send_word(12'd4095, 10'd1, 24'h7FFFFF);
		send_word(12'd1, 10'd1023, 24'h800000);
		send_word(12'd3000, 10'd1022, 24'hFFFFFF);
		send_word(12'd7, 10'd2, 24'h000001);
		send_word(12'd100, 10'd511, 24'h123456);
		drain();
		write_model_dim(11'd1);
		send_word(12'd4095, 10'd0, 24'h800000);
		send_word(12'd4095, 10'd1, 24'h7FFFFF);
		send_word(12'd2048, 10'd2, 24'h000000);
		send_word(12'd5, 10'd1023, 24'h7FFFF0);
		drain();
		write_model_dim(11'd2047);
		send_word(12'd11, 10'd1023, 24'h800010);
		send_word(12'd4095, 10'd3, 24'h000000);
		drain();
		write_model_dim(11'd0);
		send_word(12'd1234, 10'd1, 24'h000000);
		send_word(12'd4095, 10'd2, 24'hFFFFFF);

		// random phases across settings and idling patterns
		for (int p = 0; p < 12; p++) begin
			drain();
			write_model_dim(p < 6 ? dims[p] : $urandom_range(1, 2047));
			send_idle_pct  = modes[p % 4][0];
			recv_stall_pct = modes[p % 4][1];
			send_random(105);
		end

		drain();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		if (encodings.mismatches == 0 && encodings.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

`default_nettype wire

// ===== files.f =====
design/spe_pkg.sv
design/sinusoidal_position_encode_add.sv
tb/testbench.sv
